>>> design/ffra_pkg.sv
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared constants, status codes and controller/datapath interface types for
// the first-fit region allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MAX_BOUNDS = 64;
    localparam int MAX_BLOCKS = 32;
    localparam int ADDR_BITS  = 24;

    localparam int SIZE_W = ADDR_BITS + 1;
    localparam int CNT_W  = $clog2(MAX_BOUNDS + 1);
    localparam int BIDX_W = $clog2(MAX_BOUNDS);
    localparam int SLOT_W = $clog2(MAX_BLOCKS);
    localparam int SCNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int STAT_W = 3;

    localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_SIZE  = 3'd1;
    localparam logic [STAT_W-1:0] ST_INSUF      = 3'd2;
    localparam logic [STAT_W-1:0] ST_LIST_FULL  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NO_FIT     = 3'd4;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd5;
    localparam logic [STAT_W-1:0] ST_TABLE_FULL = 3'd6;

    typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_INC1, IDX_INC2} idx_op_t;
    typedef enum logic [2:0] {J_HOLD, J_IDX, J_CNTM1, J_INC, J_DEC} j_op_t;
    typedef enum logic [1:0] {S_HOLD, S_ZERO, S_INC} scnt_op_t;
    typedef enum logic [1:0] {RA_IDX, RA_J, RA_J2} rda_sel_t;
    typedef enum logic [2:0] {
        WA_IDX, WA_IDX1, WA_J, WA_J2, WA_CNT, WA_CNT1, WA_ZERO, WA_ONE
    } wa_sel_t;
    typedef enum logic [2:0] {WD_ZERO, WD_POOL, WD_EN, WD_ST, WD_RDA, WD_SUM} wd_sel_t;
    typedef enum logic [1:0] {C_HOLD, C_SUB2, C_ADD2} cnt_op_t;

    typedef struct packed {
        logic              capture;
        idx_op_t           idx_op;
        j_op_t             j_op;
        scnt_op_t          scnt_op;
        rda_sel_t          rda_sel;
        logic              fb_we;
        wa_sel_t           wa_sel;
        wd_sel_t           wd_sel;
        cnt_op_t           cnt_op;
        logic              commit_rsv;
        logic              commit_rel;
        logic              load_hit;
        logic              set_stat;
        logic [STAT_W-1:0] stat_code;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_release;
        logic size_zero;
        logic avail_lt;
        logic cnt_full;
        logic no_room;
        logic pair_end;
        logic idx_end;
        logic fits;
        logic d1_eq_end;
        logic slots_full;
        logic scnt_end;
        logic bt_hit;
        logic d0_eq_st;
        logic d1_eq_en;
        logic idx1_lt_cnt;
        logic d0_eq_en;
        logic d0_gt_en;
        logic mvd_end;
        logic j_eq_idx;
        logic out_busy;
    } dp_stat_t;

endpackage

>>> design/ffra_dp.sv
// ----------------------------------------------------------------------------
// ffra_dp
// Datapath: free-bound memory, block table, counters, pointers and the
// output register of the allocator.
// ----------------------------------------------------------------------------
module ffra_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ffra_pkg::SIZE_W-1:0]      cfg_wdata,
    input  logic                             req_type,
    input  logic [ffra_pkg::SIZE_W-1:0]      alloc_size,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   block_offset,
    input  logic                             out_ready,
    input  ffra_pkg::dp_cmd_t                cmd,
    output ffra_pkg::dp_stat_t               stat,
    output logic                             out_valid,
    output logic [ffra_pkg::STAT_W-1:0]      status,
    output logic [ffra_pkg::ADDR_BITS-1:0]   granted_offset,
    output logic [ffra_pkg::SIZE_W-1:0]      free_bytes
);
    import ffra_pkg::*;

    localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_BITS;

    // Control state.
    logic [SIZE_W-1:0]     pool_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [SIZE_W-1:0]     avail_reg;
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      j_reg;
    logic [SCNT_W-1:0]     scnt_reg;
    logic                  out_valid_reg;

    // Payload registers.
    logic                  type_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [ADDR_BITS-1:0]  off_reg;
    logic [SIZE_W-1:0]     st_reg;
    logic [SIZE_W-1:0]     en_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [STAT_W-1:0]     stat_reg;
    logic [ADDR_BITS-1:0]  gran_reg;
    logic [STAT_W-1:0]     ostat_reg;
    logic [ADDR_BITS-1:0]  ogran_reg;
    logic [SIZE_W-1:0]     ofree_reg;

    // Memories.
    logic [SIZE_W-1:0]    fb_mem [MAX_BOUNDS];
    logic [ADDR_BITS-1:0] bs_mem [MAX_BLOCKS];
    logic [SIZE_W-1:0]    be_mem [MAX_BLOCKS];
    logic [SIZE_W-1:0]    rd_a_q;
    logic [SIZE_W-1:0]    rd_b_q;
    logic [ADDR_BITS-1:0] bs_q;
    logic [SIZE_W-1:0]    be_q;

    logic [BIDX_W-1:0] ra_addr;
    logic [BIDX_W-1:0] rb_addr;
    logic [BIDX_W-1:0] wa_addr;
    logic [SIZE_W-1:0] wd_data;
    logic [SIZE_W-1:0] sum;
    logic [SIZE_W-1:0] pool_next;
    logic [CNT_W-1:0]  count_next;
    logic [SIZE_W-1:0] avail_next;
    logic [SLOT_W-1:0] free_slot;
    logic              slots_full;

    assign sum = rd_a_q + size_reg;
    assign pool_next = cfg_wdata[SIZE_W-1] ? POOL_MAX : cfg_wdata;

    always_comb
    begin
        free_slot  = '0;
        slots_full = 1'b1;
        for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
            if (!valid_reg[k]) begin
                free_slot  = SLOT_W'(k);
                slots_full = 1'b0;
            end
        end
    end

    always_comb
    begin
        case (cmd.rda_sel)
            RA_IDX:  ra_addr = BIDX_W'(idx_reg);
            RA_J:    ra_addr = BIDX_W'(j_reg);
            RA_J2:   ra_addr = BIDX_W'(j_reg + CNT_W'(2));
            default: ra_addr = BIDX_W'(idx_reg);
        endcase
        rb_addr = BIDX_W'(idx_reg + CNT_W'(1));
        case (cmd.wa_sel)
            WA_IDX:  wa_addr = BIDX_W'(idx_reg);
            WA_IDX1: wa_addr = BIDX_W'(idx_reg + CNT_W'(1));
            WA_J:    wa_addr = BIDX_W'(j_reg);
            WA_J2:   wa_addr = BIDX_W'(j_reg + CNT_W'(2));
            WA_CNT:  wa_addr = BIDX_W'(count_reg);
            WA_CNT1: wa_addr = BIDX_W'(count_reg + CNT_W'(1));
            WA_ZERO: wa_addr = BIDX_W'(0);
            WA_ONE:  wa_addr = BIDX_W'(1);
            default: wa_addr = BIDX_W'(0);
        endcase
        case (cmd.wd_sel)
            WD_ZERO: wd_data = '0;
            WD_POOL: wd_data = pool_reg;
            WD_EN:   wd_data = en_reg;
            WD_ST:   wd_data = st_reg;
            WD_RDA:  wd_data = rd_a_q;
            WD_SUM:  wd_data = sum;
            default: wd_data = '0;
        endcase
    end

    // Free-bound memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (cmd.fb_we) begin
            fb_mem[wa_addr] <= wd_data;
        end
        rd_a_q <= fb_mem[ra_addr];
        rd_b_q <= fb_mem[rb_addr];
    end

    // Block table: written on a grant, read at the scan counter.
    always_ff @(posedge clk)
    begin
        if (cmd.commit_rsv) begin
            bs_mem[free_slot] <= rd_a_q[ADDR_BITS-1:0];
            be_mem[free_slot] <= sum;
        end
        bs_q <= bs_mem[scnt_reg[SLOT_W-1:0]];
        be_q <= be_mem[scnt_reg[SLOT_W-1:0]];
    end

    always_comb
    begin
        case (cmd.cnt_op)
            C_SUB2:  count_next = count_reg - CNT_W'(2);
            C_ADD2:  count_next = count_reg + CNT_W'(2);
            default: count_next = count_reg;
        endcase
        avail_next = avail_reg;
        if (cmd.commit_rsv) begin
            avail_next = avail_reg - size_reg;
        end else if (cmd.commit_rel) begin
            avail_next = avail_reg + (en_reg - st_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pool_reg      <= POOL_MAX;
            count_reg     <= CNT_W'(2);
            avail_reg     <= POOL_MAX;
            valid_reg     <= '0;
            idx_reg       <= '0;
            j_reg         <= '0;
            scnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                pool_reg  <= pool_next;
                count_reg <= (pool_next == '0) ? CNT_W'(0) : CNT_W'(2);
                avail_reg <= pool_next;
                valid_reg <= '0;
            end else begin
                count_reg <= count_next;
                avail_reg <= avail_next;
                if (cmd.commit_rsv) begin
                    valid_reg[free_slot] <= 1'b1;
                end else if (cmd.commit_rel) begin
                    valid_reg[slot_reg] <= 1'b0;
                end
            end
            case (cmd.idx_op)
                IDX_ZERO: idx_reg <= '0;
                IDX_INC1: idx_reg <= idx_reg + CNT_W'(1);
                IDX_INC2: idx_reg <= idx_reg + CNT_W'(2);
                default:  idx_reg <= idx_reg;
            endcase
            case (cmd.j_op)
                J_IDX:   j_reg <= idx_reg;
                J_CNTM1: j_reg <= count_reg - CNT_W'(1);
                J_INC:   j_reg <= j_reg + CNT_W'(1);
                J_DEC:   j_reg <= j_reg - CNT_W'(1);
                default: j_reg <= j_reg;
            endcase
            case (cmd.scnt_op)
                S_ZERO:  scnt_reg <= '0;
                S_INC:   scnt_reg <= scnt_reg + SCNT_W'(1);
                default: scnt_reg <= scnt_reg;
            endcase
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            type_reg <= req_type;
            size_reg <= alloc_size;
            off_reg  <= block_offset;
        end
        if (cmd.load_hit) begin
            st_reg   <= {1'b0, bs_q};
            en_reg   <= be_q;
            slot_reg <= scnt_reg[SLOT_W-1:0];
        end
        if (cmd.set_stat) begin
            stat_reg <= cmd.stat_code;
            gran_reg <= '0;
        end else if (cmd.commit_rsv) begin
            stat_reg <= ST_OK;
            gran_reg <= rd_a_q[ADDR_BITS-1:0];
        end else if (cmd.commit_rel) begin
            stat_reg <= ST_OK;
            gran_reg <= '0;
        end
        if (cmd.out_load) begin
            ostat_reg <= stat_reg;
            ogran_reg <= gran_reg;
            ofree_reg <= avail_reg;
        end
    end

    always_comb
    begin
        stat.is_release  = type_reg;
        stat.size_zero   = (size_reg == '0);
        stat.avail_lt    = (avail_reg < size_reg);
        stat.cnt_full    = ({1'b0, count_reg} >= (CNT_W + 1)'(MAX_BOUNDS));
        stat.no_room     = ({1'b0, count_reg} + (CNT_W + 1)'(2) > (CNT_W + 1)'(MAX_BOUNDS));
        stat.pair_end    = ({1'b0, idx_reg} + (CNT_W + 1)'(1) >= {1'b0, count_reg});
        stat.idx_end     = (idx_reg >= count_reg);
        stat.fits        = ((rd_b_q - rd_a_q) >= size_reg);
        stat.d1_eq_end   = (rd_b_q == sum);
        stat.slots_full  = slots_full;
        stat.scnt_end    = (scnt_reg == SCNT_W'(MAX_BLOCKS));
        stat.bt_hit      = valid_reg[scnt_reg[SLOT_W-1:0]] && (bs_q == off_reg);
        stat.d0_eq_st    = (rd_a_q == st_reg);
        stat.d1_eq_en    = (rd_b_q == en_reg);
        stat.idx1_lt_cnt = ({1'b0, idx_reg} + (CNT_W + 1)'(1) < {1'b0, count_reg});
        stat.d0_eq_en    = (rd_a_q == en_reg);
        stat.d0_gt_en    = (rd_a_q > en_reg);
        stat.mvd_end     = ({1'b0, j_reg} + (CNT_W + 1)'(2) >= {1'b0, count_reg});
        stat.j_eq_idx    = (j_reg == idx_reg);
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign status         = ostat_reg;
    assign granted_offset = ogran_reg;
    assign free_bytes     = ofree_reg;

    a_count_even: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[0] == 1'b0)
        else $error("free-bound count is odd");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BOUNDS))
        else $error("free-bound count exceeds capacity");
    a_avail_le_pool: assert property (@(posedge clk) disable iff (!rst_n)
        avail_reg <= pool_reg)
        else $error("free byte count exceeds pool size");

endmodule

>>> design/ffra_ctrl.sv
// ----------------------------------------------------------------------------
// ffra_ctrl
// Controller: sequences list initialization, reserve and release requests
// over the datapath.
// ----------------------------------------------------------------------------
module ffra_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                in_valid,
    output logic                in_ready,
    input  ffra_pkg::dp_stat_t  stat,
    output ffra_pkg::dp_cmd_t   cmd
);
    import ffra_pkg::*;

    localparam logic [4:0] S_INIT0 = 5'd0;
    localparam logic [4:0] S_INIT1 = 5'd1;
    localparam logic [4:0] S_IDLE  = 5'd2;
    localparam logic [4:0] S_RCHK  = 5'd3;
    localparam logic [4:0] S_RRD   = 5'd4;
    localparam logic [4:0] S_RCMP  = 5'd5;
    localparam logic [4:0] S_MVDRD = 5'd6;
    localparam logic [4:0] S_MVDWR = 5'd7;
    localparam logic [4:0] S_LRD   = 5'd8;
    localparam logic [4:0] S_LCMP  = 5'd9;
    localparam logic [4:0] S_FRD   = 5'd10;
    localparam logic [4:0] S_FAPP  = 5'd11;
    localparam logic [4:0] S_FCMP  = 5'd12;
    localparam logic [4:0] S_MVURD = 5'd13;
    localparam logic [4:0] S_MVUWR = 5'd14;
    localparam logic [4:0] S_INS1  = 5'd15;
    localparam logic [4:0] S_INS2  = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_INIT0:
            begin
                cmd.fb_we  = 1'b1;
                cmd.wa_sel = WA_ZERO;
                cmd.wd_sel = WD_ZERO;
                state_next = S_INIT1;
            end
            S_INIT1:
            begin
                cmd.fb_we  = 1'b1;
                cmd.wa_sel = WA_ONE;
                cmd.wd_sel = WD_POOL;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    cmd.idx_op  = IDX_ZERO;
                    cmd.scnt_op = S_ZERO;
                    state_next  = S_RCHK;
                end
            end
            S_RCHK:
            begin
                if (stat.is_release) begin
                    state_next = S_LRD;
                end else begin
                    state_next = S_FIN;
                    cmd.set_stat = 1'b1;
                    if (stat.size_zero) begin
                        cmd.stat_code = ST_ZERO_SIZE;
                    end else if (stat.avail_lt) begin
                        cmd.stat_code = ST_INSUF;
                    end else if (stat.cnt_full) begin
                        cmd.stat_code = ST_LIST_FULL;
                    end else begin
                        cmd.set_stat = 1'b0;
                        state_next   = S_RRD;
                    end
                end
            end
            S_RRD:
            begin
                cmd.rda_sel = RA_IDX;
                if (stat.pair_end) begin
                    cmd.set_stat  = 1'b1;
                    cmd.stat_code = ST_NO_FIT;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_RCMP;
                end
            end
            S_RCMP:
            begin
                if (stat.fits) begin
                    if (stat.slots_full) begin
                        cmd.set_stat  = 1'b1;
                        cmd.stat_code = ST_TABLE_FULL;
                        state_next    = S_FIN;
                    end else begin
                        cmd.commit_rsv = 1'b1;
                        if (stat.d1_eq_end) begin
                            cmd.j_op   = J_IDX;
                            state_next = S_MVDRD;
                        end else begin
                            cmd.fb_we  = 1'b1;
                            cmd.wa_sel = WA_IDX;
                            cmd.wd_sel = WD_SUM;
                            state_next = S_FIN;
                        end
                    end
                end else begin
                    cmd.idx_op = IDX_INC2;
                    state_next = S_RRD;
                end
            end
            S_MVDRD:
            begin
                cmd.rda_sel = RA_J2;
                if (stat.mvd_end) begin
                    cmd.cnt_op = C_SUB2;
                    state_next = S_FIN;
                end else begin
                    state_next = S_MVDWR;
                end
            end
            S_MVDWR:
            begin
                cmd.fb_we  = 1'b1;
                cmd.wa_sel = WA_J;
                cmd.wd_sel = WD_RDA;
                cmd.j_op   = J_INC;
                state_next = S_MVDRD;
            end
            S_LRD:
            begin
                if (stat.scnt_end) begin
                    cmd.set_stat  = 1'b1;
                    cmd.stat_code = ST_NOT_FOUND;
                    state_next    = S_FIN;
                end else begin
                    state_next = S_LCMP;
                end
            end
            S_LCMP:
            begin
                if (stat.bt_hit) begin
                    cmd.load_hit = 1'b1;
                    cmd.idx_op   = IDX_ZERO;
                    state_next   = S_FRD;
                end else begin
                    cmd.scnt_op = S_INC;
                    state_next  = S_LRD;
                end
            end
            S_FRD:
            begin
                cmd.rda_sel = RA_IDX;
                if (stat.idx_end) begin
                    if (stat.no_room) begin
                        cmd.set_stat  = 1'b1;
                        cmd.stat_code = ST_LIST_FULL;
                        state_next    = S_FIN;
                    end else begin
                        cmd.fb_we  = 1'b1;
                        cmd.wa_sel = WA_CNT;
                        cmd.wd_sel = WD_ST;
                        state_next = S_FAPP;
                    end
                end else begin
                    state_next = S_FCMP;
                end
            end
            S_FAPP:
            begin
                cmd.fb_we      = 1'b1;
                cmd.wa_sel     = WA_CNT1;
                cmd.wd_sel     = WD_EN;
                cmd.cnt_op     = C_ADD2;
                cmd.commit_rel = 1'b1;
                state_next     = S_FIN;
            end
            S_FCMP:
            begin
                if (stat.d0_eq_st) begin
                    cmd.commit_rel = 1'b1;
                    if (stat.idx1_lt_cnt && stat.d1_eq_en) begin
                        cmd.j_op   = J_IDX;
                        state_next = S_MVDRD;
                    end else begin
                        cmd.fb_we  = 1'b1;
                        cmd.wa_sel = WA_IDX;
                        cmd.wd_sel = WD_EN;
                        state_next = S_FIN;
                    end
                end else if (stat.d0_eq_en) begin
                    cmd.commit_rel = 1'b1;
                    cmd.fb_we      = 1'b1;
                    cmd.wa_sel     = WA_IDX;
                    cmd.wd_sel     = WD_ST;
                    state_next     = S_FIN;
                end else if (stat.d0_gt_en) begin
                    if (stat.no_room) begin
                        cmd.set_stat  = 1'b1;
                        cmd.stat_code = ST_LIST_FULL;
                        state_next    = S_FIN;
                    end else begin
                        cmd.j_op   = J_CNTM1;
                        state_next = S_MVURD;
                    end
                end else begin
                    cmd.idx_op = IDX_INC1;
                    state_next = S_FRD;
                end
            end
            S_MVURD:
            begin
                cmd.rda_sel = RA_J;
                state_next  = S_MVUWR;
            end
            S_MVUWR:
            begin
                cmd.fb_we  = 1'b1;
                cmd.wa_sel = WA_J2;
                cmd.wd_sel = WD_RDA;
                if (stat.j_eq_idx) begin
                    state_next = S_INS1;
                end else begin
                    cmd.j_op   = J_DEC;
                    state_next = S_MVURD;
                end
            end
            S_INS1:
            begin
                cmd.fb_we  = 1'b1;
                cmd.wa_sel = WA_IDX;
                cmd.wd_sel = WD_ST;
                state_next = S_INS2;
            end
            S_INS2:
            begin
                cmd.fb_we      = 1'b1;
                cmd.wa_sel     = WA_IDX1;
                cmd.wd_sel     = WD_EN;
                cmd.cnt_op     = C_ADD2;
                cmd.commit_rel = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT0;
            end
        endcase
        if (cfg_we) begin
            state_next = S_INIT0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_INIT0;
        end else begin
            state_reg <= state_next;
        end
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> state_reg == S_IDLE)
        else $error("request captured outside idle");
    a_one_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.commit_rsv && cmd.commit_rel))
        else $error("reserve and release committed together");
    a_fin_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && !cfg_we) |=> state_reg == S_IDLE)
        else $error("result load did not return to idle");

endmodule

>>> design/first_fit_region_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_region_allocator
// First-fit allocator over an address-sorted free-region list with
// coalescing on release; one result item per request item.
// ----------------------------------------------------------------------------
// Usage: a request item (req_type, alloc_size, block_offset) enters on the
// in_valid/in_ready channel and exactly one result item (status,
// granted_offset, free_bytes) leaves on the out_valid/out_ready channel.
// Requests are handled one at a time by a controller that walks a 64-entry
// free-bound memory and a 32-entry block table. A reserve examines the free
// regions in address order and shifts the following bounds down when a
// region is consumed. A release scans the block-table slots, compares
// bounds and shifts bounds up on an insert.
// The result sits in an output register; the next request is accepted as
// soon as the block is idle, even while that result waits. If the receiver
// still holds off the previous result when a new one is ready, the block
// waits in its final state until the output register frees up.
// After reset, and after every write of cfg_wdata (the pool size, clamped
// to 2^24), the block writes the single initial free region before it
// accepts requests.
// ----------------------------------------------------------------------------
module first_fit_region_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ffra_pkg::SIZE_W-1:0]      cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [ffra_pkg::SIZE_W-1:0]      alloc_size,
    input  logic [ffra_pkg::ADDR_BITS-1:0]   block_offset,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ffra_pkg::STAT_W-1:0]      status,
    output logic [ffra_pkg::ADDR_BITS-1:0]   granted_offset,
    output logic [ffra_pkg::SIZE_W-1:0]      free_bytes
);
    import ffra_pkg::*;

    // Command and status between the sequencer and the datapath.
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller decides what happens each cycle.
    ffra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds all storage and the result register.
    ffra_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_type       (req_type),
        .alloc_size     (alloc_size),
        .block_offset   (block_offset),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .status         (status),
        .granted_offset (granted_offset),
        .free_bytes     (free_bytes)
    );

endmodule
